FILE: src/pal_pkg.sv
// ----------------------------------------------------------------------------
// pal_pkg: shared types and constants for the positional array list
// Sizes of the entry row, operation and status codes, and the control
// struct that the top level broadcasts to every storage cell.
// ----------------------------------------------------------------------------
`default_nettype none

package pal_pkg;

    // Entry row size and derived widths
    localparam int DEPTH   = 16;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);

    // Fixed field widths of the item ports
    localparam int DATA_W  = 32;
    localparam int KIND_W  = 3;
    localparam int POS_W   = 5;
    localparam int FIDX_W  = 4;
    localparam int COUNT_W = 5;
    localparam int STAT_W  = 2;

    // Common width for comparing positions, indexes and the count
    localparam int CMP_W   = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

    typedef enum logic [KIND_W-1:0] {
        KIND_READ   = 3'd0,
        KIND_WRITE  = 3'd1,
        KIND_INSERT = 3'd2,
        KIND_REMOVE = 3'd3,
        KIND_SEARCH = 3'd4
    } kind_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Update command seen by every cell of the row
    typedef struct packed {
        logic                     do_write;
        logic                     do_insert;
        logic                     do_remove;
        logic [POS_W-1:0]         pos;
        logic [CNT_W-1:0]         count;
        logic signed [DATA_W-1:0] value;
    } bcast_t;

endpackage

`default_nettype wire

FILE: src/pal_cell.sv
// ----------------------------------------------------------------------------
// pal_cell: one storage cell of the entry row
// Holds one entry, loads a new value, takes its left neighbor on an insert
// or its right neighbor on a remove, and flags a search match.
// ----------------------------------------------------------------------------
`default_nettype none

module pal_cell (
    input  wire logic                             clk,
    input  wire logic [pal_pkg::IDX_W-1:0]        idx,
    input  wire pal_pkg::bcast_t                  bc,
    input  wire logic signed [pal_pkg::DATA_W-1:0] left_data,
    input  wire logic signed [pal_pkg::DATA_W-1:0] right_data,
    output logic signed [pal_pkg::DATA_W-1:0]     data,
    output logic                                  match
);
    import pal_pkg::*;

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;
    logic [CMP_W-1:0]         idx_c;
    logic [CMP_W-1:0]         nxt_c;
    logic [CMP_W-1:0]         pos_c;
    logic [CMP_W-1:0]         cnt_c;

    assign idx_c = CMP_W'(idx);
    assign nxt_c = CMP_W'(idx) + CMP_W'(1);
    assign pos_c = CMP_W'(bc.pos);
    assign cnt_c = CMP_W'(bc.count);

    // Pick the next entry value
    always_comb
    begin
        data_next = data_reg;
        if (bc.do_write && (idx_c == pos_c))
        begin
            data_next = bc.value;
        end
        else if (bc.do_insert)
        begin
            if (idx_c == pos_c)
            begin
                data_next = bc.value;
            end
            else if ((idx_c > pos_c) && (idx_c <= cnt_c))
            begin
                data_next = left_data;
            end
        end
        else if (bc.do_remove && (idx_c >= pos_c) && (nxt_c < cnt_c))
        begin
            data_next = right_data;
        end
    end

    // Hold the entry
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    // Flag a match only on an occupied entry
    assign match = (idx_c < cnt_c) && (data_reg == bc.value);
    assign data  = data_reg;

endmodule

`default_nettype wire

FILE: src/pal_search.sv
// ----------------------------------------------------------------------------
// pal_search: lowest-position match encoder
// Turns the match flags of the cell row into a hit flag and the index of
// the lowest matching cell.
// ----------------------------------------------------------------------------
`default_nettype none

module pal_search (
    input  wire logic [pal_pkg::DEPTH-1:0]  match,
    output logic                            hit,
    output logic [pal_pkg::IDX_W-1:0]       hit_idx
);
    import pal_pkg::*;

    // Scan from the top so the lowest match wins
    always_comb
    begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int i = DEPTH - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                hit     = 1'b1;
                hit_idx = IDX_W'(i);
            end
        end
    end

endmodule

`default_nettype wire

FILE: src/positional_array_list.sv
// Result: registered into the output register in the cycle after its item
//   is accepted.
// Throughput: one item per cycle while each result is taken; the cell row
//   updates and compares all entries on accept; one output register sets the pace.
// Reset: clears the entry count and the result valid flag; entry storage and
//   the result payload are not cleared, and only entries below the count are read.
// ----------------------------------------------------------------------------
// positional_array_list: ordered list with insert, remove and search
// A row of storage cells holds the entries; insert and remove shift the row
// in one step, search compares every cell at once.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_array_list (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic [pal_pkg::KIND_W-1:0]           kind,
    input  wire logic [pal_pkg::POS_W-1:0]            position,
    input  wire logic signed [pal_pkg::DATA_W-1:0]    value,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic signed [pal_pkg::DATA_W-1:0]         read_value,
    output logic                                      found,
    output logic [pal_pkg::FIDX_W-1:0]                found_index,
    output logic [pal_pkg::COUNT_W-1:0]               count,
    output logic [pal_pkg::STAT_W-1:0]                status
);
    import pal_pkg::*;

    logic                     accept;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic                     pos_lt;
    logic                     pos_le;
    logic                     is_full;
    bcast_t                   bc;
    logic signed [DATA_W-1:0] cell_data [DEPTH];
    logic [DEPTH-1:0]         cell_match;
    logic                     hit;
    logic [IDX_W-1:0]         hit_idx;

    logic signed [DATA_W-1:0] res_rd;
    logic                     res_hit;
    logic [IDX_W-1:0]         res_idx;
    status_t                  res_status;

    logic                     out_valid_reg;
    logic signed [DATA_W-1:0] rd_reg;
    logic                     found_reg;
    logic [FIDX_W-1:0]        fidx_reg;
    logic [COUNT_W-1:0]       count_out_reg;
    status_t                  status_reg;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    assign pos_lt  = CMP_W'(position) <  CMP_W'(count_reg);
    assign pos_le  = CMP_W'(position) <= CMP_W'(count_reg);
    assign is_full = count_reg == CNT_W'(DEPTH);

    // Decode the operation and check the position
    always_comb
    begin
        res_rd       = '0;
        res_hit      = 1'b0;
        res_idx      = '0;
        res_status   = ST_OK;
        count_next   = count_reg;
        bc.do_write  = 1'b0;
        bc.do_insert = 1'b0;
        bc.do_remove = 1'b0;
        bc.pos       = position;
        bc.count     = count_reg;
        bc.value     = value;
        unique case (kind)
            KIND_READ:
            begin
                if (pos_lt)
                begin
                    res_rd = cell_data[position[IDX_W-1:0]];
                end
                else
                begin
                    res_status = ST_RANGE;
                end
            end
            KIND_WRITE:
            begin
                if (pos_lt)
                begin
                    bc.do_write = accept;
                end
                else
                begin
                    res_status = ST_RANGE;
                end
            end
            KIND_INSERT:
            begin
                if (!pos_le)
                begin
                    res_status = ST_RANGE;
                end
                else if (is_full)
                begin
                    res_status = ST_FULL;
                end
                else
                begin
                    bc.do_insert = accept;
                    count_next   = count_reg + CNT_W'(1);
                end
            end
            KIND_REMOVE:
            begin
                if (pos_lt)
                begin
                    bc.do_remove = accept;
                    count_next   = count_reg - CNT_W'(1);
                end
                else
                begin
                    res_status = ST_RANGE;
                end
            end
            KIND_SEARCH:
            begin
                res_hit = hit;
                res_idx = hit_idx;
            end
            default:
            begin
                res_status = ST_OK;
            end
        endcase
    end

    // Row of storage cells
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [DATA_W-1:0] left_d;
        logic signed [DATA_W-1:0] right_d;

        if (i == 0)
        begin : g_first
            assign left_d = '0;
        end
        else
        begin : g_left
            assign left_d = cell_data[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_d = '0;
        end
        else
        begin : g_right
            assign right_d = cell_data[i+1];
        end

        pal_cell u_cell (
            .clk        (clk),
            .idx        (IDX_W'(i)),
            .bc         (bc),
            .left_data  (left_d),
            .right_data (right_d),
            .data       (cell_data[i]),
            .match      (cell_match[i])
        );
    end

    pal_search u_search (
        .match   (cell_match),
        .hit     (hit),
        .hit_idx (hit_idx)
    );

    // Advance the entry count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (accept)
        begin
            count_reg <= count_next;
        end
    end

    // Hold the result until it is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_reg        <= res_rd;
            found_reg     <= res_hit;
            fidx_reg      <= FIDX_W'(res_idx);
            count_out_reg <= COUNT_W'(count_next);
            status_reg    <= res_status;
        end
    end

    assign out_valid   = out_valid_reg;
    assign read_value  = rd_reg;
    assign found       = found_reg;
    assign found_index = fidx_reg;
    assign count       = count_out_reg;
    assign status      = status_reg;

    // Count never exceeds the row size
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above row size");

    // A good insert grows the list by one
    a_insert_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (kind == KIND_INSERT) && (res_status == ST_OK))
        |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("insert did not grow the list");

    // A full report comes only with a full list
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg == ST_FULL))
        |-> (count_out_reg == COUNT_W'(DEPTH)))
        else $error("full status with room left");

    // A search hit lies inside the list
    a_hit_inside: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && found_reg)
        |-> ((COUNT_W'(fidx_reg) < count_out_reg) && (status_reg == ST_OK)))
        else $error("search hit outside the list");

endmodule

`default_nettype wire
